>>> sv/pgq_pkg.sv
package pgq_pkg;
  localparam int unsigned SumWidth     = 32;
  localparam int unsigned SamplesWidth = 16;
  localparam int unsigned PixWidth     = 8;
  localparam int unsigned NumLanes     = 3;
  localparam logic [SamplesWidth-1:0] SamplesReset = 16'd1;
  localparam logic [SumWidth-1:0] SatLimit = 32'd65025;

  typedef struct packed {
    logic [SumWidth-1:0] red_sum;
    logic [SumWidth-1:0] green_sum;
    logic [SumWidth-1:0] blue_sum;
  } pix_in_t;

  typedef struct packed {
    logic [PixWidth-1:0] red_out;
    logic [PixWidth-1:0] green_out;
    logic [PixWidth-1:0] blue_out;
  } pix_out_t;
endpackage

>>> sv/pgq_if.sv
interface pgq_in_if;
  logic              valid;
  logic              ready;
  pgq_pkg::pix_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pgq_out_if;
  logic              valid;
  logic              ready;
  pgq_pkg::pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/pgq_lane.sv
// one color channel: restoring divide (one quotient bit per stage), then
// bitwise square root (one root bit per stage)
module pgq_lane #(
  parameter int unsigned SamplesWidth = pgq_pkg::SamplesWidth
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [pgq_pkg::SumWidth-1:0]  sum_i,
  input  logic [SamplesWidth-1:0]       samples_i,
  output logic [pgq_pkg::PixWidth-1:0]  pix_o
);
  localparam int unsigned SumWidth = pgq_pkg::SumWidth;
  localparam int unsigned PixWidth = pgq_pkg::PixWidth;
  localparam int unsigned RemW     = SamplesWidth + 1;

  // divider stage registers, index k holds state after k quotient bits
  logic [SumWidth-1:0]     num_q [1:SumWidth];
  logic [RemW-1:0]         rem_q [1:SumWidth];
  logic [SamplesWidth-1:0] den_q [1:SumWidth];

  for (genvar k = 0; k < SumWidth; k++) begin : g_div
    logic [SumWidth-1:0]     num_cur;
    logic [RemW-1:0]         rem_cur;
    logic [SamplesWidth-1:0] den_cur;
    logic [RemW:0]           trial;
    logic                    take;
    if (k == 0) begin : g_first
      assign num_cur = sum_i;
      assign rem_cur = '0;
      assign den_cur = samples_i;
    end else begin : g_next
      assign num_cur = num_q[k];
      assign rem_cur = rem_q[k];
      assign den_cur = den_q[k];
    end
    always_comb begin
      trial = {rem_cur, num_cur[SumWidth-1]};
      take  = trial >= {2'b00, den_cur};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= {num_cur[SumWidth-2:0], take};
        rem_q[k+1] <= take ? RemW'(trial - {2'b00, den_cur}) : RemW'(trial);
        den_q[k+1] <= den_cur;
      end
    end
  end

  // quotient after the last stage (zero divisor yields all ones)
  logic [SumWidth-1:0] rq_q   [1:PixWidth];
  logic [PixWidth-1:0] root_q [1:PixWidth];
  logic                sat_q  [1:PixWidth];

  for (genvar b = 0; b < PixWidth; b++) begin : g_sqrt
    logic [SumWidth-1:0]   rq_cur;
    logic [PixWidth-1:0]   root_cur;
    logic                  sat_cur;
    logic [PixWidth-1:0]   trial;
    logic [2*PixWidth-1:0] sq;
    if (b == 0) begin : g_first
      assign rq_cur   = num_q[SumWidth];
      assign root_cur = '0;
      assign sat_cur  = num_q[SumWidth] >= pgq_pkg::SatLimit;
    end else begin : g_next
      assign rq_cur   = rq_q[b];
      assign root_cur = root_q[b];
      assign sat_cur  = sat_q[b];
    end
    always_comb begin
      trial = root_cur | (PixWidth'(1) << (PixWidth-1-b));
      sq    = trial * trial;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rq_q[b+1]   <= rq_cur;
        sat_q[b+1]  <= sat_cur;
        root_q[b+1] <= (SumWidth'(sq) <= rq_cur) ? trial : root_cur;
      end
    end
  end

  assign pix_o = sat_q[PixWidth] ? '1 : root_q[PixWidth];
endmodule

>>> sv/pixel_gamma_quantizer.sv
// each beat passes 32 divide stages, then 8 root stages, from input beat to output beat
// throughput: one pixel per cycle while the pipeline is not stalled; three lanes run the channels side by side
// the pipeline advances whenever its output slot is empty or being taken
// reset: samples_per_pixel returns to 1, all valid flags clear
// stage data registers are not reset
module pixel_gamma_quantizer #(
  parameter int unsigned SamplesWidth = pgq_pkg::SamplesWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [SamplesWidth-1:0] cfg_wdata_i,
  pgq_in_if.sink                  in_if,
  pgq_out_if.source               out_if
);
  localparam int unsigned Depth = pgq_pkg::SumWidth + pgq_pkg::PixWidth;

  logic [SamplesWidth-1:0] samples_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= SamplesWidth'(pgq_pkg::SamplesReset);
    end else if (cfg_we_i) begin
      samples_q <= cfg_wdata_i;
    end
  end

  // whole pipe moves together; stalls only when last stage is full and blocked
  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  logic [pgq_pkg::PixWidth-1:0] red_pix;
  logic [pgq_pkg::PixWidth-1:0] grn_pix;
  logic [pgq_pkg::PixWidth-1:0] blu_pix;

  // merge: lanes feed the three fields of one output beat
  pgq_lane #(.SamplesWidth(SamplesWidth)) u_red (
    .clk_i, .en_i(en), .sum_i(in_if.data.red_sum), .samples_i(samples_q),
    .pix_o(red_pix));
  pgq_lane #(.SamplesWidth(SamplesWidth)) u_grn (
    .clk_i, .en_i(en), .sum_i(in_if.data.green_sum), .samples_i(samples_q),
    .pix_o(grn_pix));
  pgq_lane #(.SamplesWidth(SamplesWidth)) u_blu (
    .clk_i, .en_i(en), .sum_i(in_if.data.blue_sum), .samples_i(samples_q),
    .pix_o(blu_pix));

  assign out_if.valid = vld_q[Depth-1];
  assign out_if.data  = {red_pix, grn_pix, blu_pix};

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed while stalled");
  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |-> !in_if.ready)
    else $error("input taken while pipe stalled");
  a_vld_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> vld_q[0])
    else $error("accepted beat lost");
endmodule
